// ===== rtl/core/avd_pkg.sv =====
// Shared types, widths and register codes for the affine voxel displacement block.
package avd_pkg;

    localparam int IndexBits = 10;
    localparam int SpW       = 16;
    localparam int CoefW     = 17;
    localparam int TW        = IndexBits + 2;
    localparam int CW        = SpW + 1 + TW;
    localparam int PW        = CoefW + CW;
    localparam int DW        = PW + 2;
    localparam int MW        = 32;
    localparam int SqW       = 64;
    localparam int RootSteps = 32;
    localparam int ResW      = 24;
    localparam int RegW      = 48;
    localparam int CfgIdxW   = 3;

    localparam logic [CfgIdxW-1:0] RegRowX    = 3'd0;
    localparam logic [CfgIdxW-1:0] RegRowY    = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRowZ    = 3'd2;
    localparam logic [CfgIdxW-1:0] RegTrans   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegSpacing = 3'd4;
    localparam logic [CfgIdxW-1:0] RegExtent  = 3'd5;

    typedef struct packed {
        logic [IndexBits-1:0] col_index;
        logic [IndexBits-1:0] row_index;
        logic [IndexBits-1:0] slice_index;
    } in_t;

    typedef struct packed {
        logic [ResW-1:0] displacement;
        logic            saturated;
    } out_t;

    typedef struct packed {
        logic [2:0][RegW-1:0]     linear;
        logic [RegW-1:0]          translation;
        logic [RegW-1:0]          spacing;
        logic [3*IndexBits-1:0]   extent;
    } cfg_t;

endpackage

// ===== rtl/core/avd_sqrt_cell.sv =====
// One digit cell of the pipelined integer square root chain.
module avd_sqrt_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      valid_in,
    input  logic [avd_pkg::SqW-1:0]   rem_in,
    input  logic [avd_pkg::SqW-1:0]   root_in,
    input  logic [avd_pkg::SqW-1:0]   weight,
    output logic                      valid_out,
    output logic [avd_pkg::SqW-1:0]   rem_out,
    output logic [avd_pkg::SqW-1:0]   root_out
);

    logic                    valid_reg;
    logic [avd_pkg::SqW-1:0] rem_reg;
    logic [avd_pkg::SqW-1:0] root_reg;
    logic [avd_pkg::SqW-1:0] rem_next;
    logic [avd_pkg::SqW-1:0] root_next;
    logic [avd_pkg::SqW-1:0] trial;

    always_comb
    begin
        trial = root_in + weight;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + weight;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign valid_out = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;

endmodule

// ===== rtl/core/avd_affine.sv =====
// Coordinate, affine difference and sum-of-squares pipeline ahead of the root chain.
module avd_affine (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  avd_pkg::in_t             request,
    input  avd_pkg::cfg_t            cfg,
    output logic                     valid_out,
    output logic [avd_pkg::SqW-1:0]  sum_out
);

    localparam int IB = avd_pkg::IndexBits;
    localparam int DW = avd_pkg::DW;

    logic [5:0] valid_reg;

    logic [2:0][IB-1:0]                idx;
    logic signed [avd_pkg::TW-1:0]     t_val    [3];
    logic signed [avd_pkg::CW-1:0]     c_next   [3];
    logic signed [avd_pkg::CW-1:0]     c_reg    [3];
    logic signed [avd_pkg::PW-1:0]     p_next   [3][3];
    logic signed [avd_pkg::PW-1:0]     p_reg    [3][3];
    logic signed [DW-1:0]              d_next   [3];
    logic signed [DW-1:0]              d_reg    [3];
    logic [avd_pkg::MW-1:0]            m_next   [3];
    logic [avd_pkg::MW-1:0]            m_reg    [3];
    logic [avd_pkg::SqW-1:0]           sq_next  [3];
    logic [avd_pkg::SqW-1:0]           sq_reg   [3];
    logic [avd_pkg::SqW-1:0]           sum_next;
    logic [avd_pkg::SqW-1:0]           sum_reg;

    assign idx[0] = request.col_index;
    assign idx[1] = request.row_index;
    assign idx[2] = request.slice_index;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            t_val[a]  = $signed({1'b0, idx[a], 1'b0})
                      - $signed({2'b00, cfg.extent[IB*a +: IB]});
            c_next[a] = $signed({1'b0, cfg.spacing[16*a +: 16]}) * t_val[a];
        end
    end

    always_comb
    begin
        logic signed [avd_pkg::CoefW-1:0] coef;
        coef = '0;
        for (int a = 0; a < 3; a++)
        begin
            for (int n = 0; n < 3; n++)
            begin
                coef = avd_pkg::CoefW'($signed(cfg.linear[a][16*n +: 16]));
                if (n == a)
                    coef = coef - avd_pkg::CoefW'(16384);
                p_next[a][n] = coef * c_reg[n];
            end
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            d_next[a] = DW'(p_reg[a][0]) + DW'(p_reg[a][1]) + DW'(p_reg[a][2])
                      + (DW'($signed(cfg.translation[16*a +: 16])) <<< 21);
        end
    end

    always_comb
    begin
        logic [DW-1:0] mag;
        logic [DW:0]   rnd;
        mag = '0;
        rnd = '0;
        for (int a = 0; a < 3; a++)
        begin
            mag = d_reg[a][DW-1] ? DW'(-d_reg[a]) : DW'(d_reg[a]);
            rnd = ({1'b0, mag} + (DW+1)'(16384)) >> 15;
            if (rnd > (DW+1)'(64'h8000_0000))
                m_next[a] = 32'h8000_0000;
            else
                m_next[a] = rnd[avd_pkg::MW-1:0];
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            sq_next[a] = m_reg[a] * m_reg[a];
        sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[4:0], start};
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        p_reg   <= p_next;
        d_reg   <= d_next;
        m_reg   <= m_next;
        sq_reg  <= sq_next;
        sum_reg <= sum_next;
    end

    assign valid_out = valid_reg[5];
    assign sum_out   = sum_reg;

endmodule

// ===== rtl/core/affine_voxel_displacement.sv =====
// Top level: configuration registers, affine front end, square root cell chain and rounding.
// The block takes one voxel index on every clock cycle and busy never rises. Each
// request yields one result, marked by done for a single cycle, after it passes
// through the registered coordinate, affine and sum-of-squares arithmetic, each of
// the 32 cells of the square root chain, and a final register for rounding
// and saturation. Results cannot be held off, so the receiver must take each one
// as it appears. Configuration writes are always accepted.
module affine_voxel_displacement (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  avd_pkg::in_t                  request,
    output logic                          done,
    output avd_pkg::out_t                 result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [avd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [avd_pkg::RegW-1:0]      cfg_data
);

    localparam int IB = avd_pkg::IndexBits;
    localparam int NS = avd_pkg::RootSteps;

    avd_pkg::cfg_t cfg_reg;
    avd_pkg::cfg_t cfg_next;

    logic                      front_valid;
    logic [avd_pkg::SqW-1:0]   front_sum;
    logic                      vld  [NS+1];
    logic [avd_pkg::SqW-1:0]   rem  [NS+1];
    logic [avd_pkg::SqW-1:0]   root [NS+1];
    logic [32:0]               code;
    logic                      done_reg;
    avd_pkg::out_t             result_reg;
    avd_pkg::out_t             result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                avd_pkg::RegRowX:    cfg_next.linear[0]   = cfg_data;
                avd_pkg::RegRowY:    cfg_next.linear[1]   = cfg_data;
                avd_pkg::RegRowZ:    cfg_next.linear[2]   = cfg_data;
                avd_pkg::RegTrans:   cfg_next.translation = cfg_data;
                avd_pkg::RegSpacing: cfg_next.spacing     = cfg_data;
                avd_pkg::RegExtent:  cfg_next.extent      = cfg_data[3*IB-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.linear[0]   <= avd_pkg::RegW'(64'd16384);
            cfg_reg.linear[1]   <= avd_pkg::RegW'(64'd16384 << 16);
            cfg_reg.linear[2]   <= avd_pkg::RegW'(64'd16384 << 32);
            cfg_reg.translation <= '0;
            cfg_reg.spacing     <= {16'd4096, 16'd4096, 16'd4096};
            cfg_reg.extent      <= {IB'(255), IB'(255), IB'(255)};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    avd_affine u_affine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .cfg       (cfg_reg),
        .valid_out (front_valid),
        .sum_out   (front_sum)
    );

    assign vld[0]  = front_valid;
    assign rem[0]  = front_sum;
    assign root[0] = '0;

    for (genvar g = 0; g < NS; g++)
    begin : g_root
        avd_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (vld[g]),
            .rem_in    (rem[g]),
            .root_in   (root[g]),
            .weight    (avd_pkg::SqW'(1) << (2 * (NS - 1 - g))),
            .valid_out (vld[g+1]),
            .rem_out   (rem[g+1]),
            .root_out  (root[g+1])
        );
    end

    always_comb
    begin
        code = ({1'b0, root[NS][31:0]} + 33'd8) >> 4;
        if (code > 33'(24'hFF_FFFF))
        begin
            result_next.displacement = '1;
            result_next.saturated    = 1'b1;
        end
        else
        begin
            result_next.displacement = code[avd_pkg::ResW-1:0];
            result_next.saturated    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld[NS];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== dv/affine_voxel_displacement_test.sv =====
// Self-checking testbench for the affine voxel displacement block, with a predicting scoreboard.
`timescale 1ns / 100ps

module affine_voxel_displacement_test;

    class displacement_board;
        logic [avd_pkg::RegW-1:0] regs [6];
        avd_pkg::out_t            pending_disp [$];
        int                       errors;
        int                       checked;
        int                       sat_seen;

        function new();
            errors   = 0;
            checked  = 0;
            sat_seen = 0;
            reset_regs();
        endfunction

        function void reset_regs();
            regs[avd_pkg::RegRowX]    = 48'd16384;
            regs[avd_pkg::RegRowY]    = 48'd16384 << 16;
            regs[avd_pkg::RegRowZ]    = 48'd16384 << 32;
            regs[avd_pkg::RegTrans]   = '0;
            regs[avd_pkg::RegSpacing] = {16'd4096, 16'd4096, 16'd4096};
            regs[avd_pkg::RegExtent]  = {18'd0, 10'd255, 10'd255, 10'd255};
        endfunction

        function void write_reg(logic [avd_pkg::CfgIdxW-1:0] idx,
                                logic [avd_pkg::RegW-1:0] data);
            if (idx == avd_pkg::RegExtent)
                regs[idx] = {18'd0, data[3*avd_pkg::IndexBits-1:0]};
            else if (idx < avd_pkg::RegExtent)
                regs[idx] = data;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_request(avd_pkg::in_t req);
            longint          pos [3];
            longint          diff;
            longint          coef;
            longint          sp;
            longint          ext;
            longint unsigned mag;
            longint unsigned total;
            longint unsigned code;
            logic [avd_pkg::IndexBits-1:0] idx [3];
            logic [15:0]     h;
            avd_pkg::out_t   res;
            idx[0] = req.col_index;
            idx[1] = req.row_index;
            idx[2] = req.slice_index;
            total = 0;
            for (int a = 0; a < 3; a++)
            begin
                sp = longint'(regs[avd_pkg::RegSpacing][16*a +: 16]);
                ext = longint'(regs[avd_pkg::RegExtent][avd_pkg::IndexBits*a +: avd_pkg::IndexBits]);
                pos[a] = 2 * longint'(idx[a]) * sp - sp * ext;
            end
            for (int a = 0; a < 3; a++)
            begin
                h = regs[avd_pkg::RegTrans][16*a +: 16];
                diff = longint'($signed(h)) * 2097152;
                for (int n = 0; n < 3; n++)
                begin
                    h = regs[a][16*n +: 16];
                    coef = longint'($signed(h));
                    if (n == a)
                        coef = coef - 16384;
                    diff = diff + coef * pos[n];
                end
                mag = (diff < 0) ? longint'(-diff) : longint'(diff);
                mag = (mag + (64'd1 << 14)) >> 15;
                if (mag > (64'd1 << 31))
                    mag = 64'd1 << 31;
                total = total + mag * mag;
            end
            code = (root_floor(total) + 8) >> 4;
            if (code > 64'd16777215)
            begin
                res.displacement = '1;
                res.saturated = 1'b1;
            end
            else
            begin
                res.displacement = code[avd_pkg::ResW-1:0];
                res.saturated = 1'b0;
            end
            pending_disp.push_back(res);
        endfunction

        function void check_result(avd_pkg::out_t got);
            avd_pkg::out_t want;
            if (pending_disp.size() == 0)
            begin
                $display("%0t: unexpected result displacement %0d saturated %0b",
                         $time, got.displacement, got.saturated);
                errors++;
                return;
            end
            want = pending_disp.pop_front();
            checked++;
            if (got.saturated)
                sat_seen++;
            if (got.displacement !== want.displacement)
            begin
                $display("%0t: displacement expected %0d actual %0d",
                         $time, want.displacement, got.displacement);
                errors++;
            end
            if (got.saturated !== want.saturated)
            begin
                $display("%0t: saturated expected %0b actual %0b",
                         $time, want.saturated, got.saturated);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    avd_pkg::in_t                  request;
    logic                          done;
    avd_pkg::out_t                 result;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [avd_pkg::CfgIdxW-1:0]   cfg_index;
    logic [avd_pkg::RegW-1:0]      cfg_data;

    displacement_board board;
    int                idle_cycles;
    int                sent;
    bit                allow_gaps;

    localparam int WatchLimit = 4000;

    affine_voxel_displacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(negedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WatchLimit)
        begin
            $display("[affine_voxel_displacement] ERROR");
            $finish;
        end
    end

    task automatic send_request(avd_pkg::in_t req);
        start <= 1'b1;
        request <= req;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        board.note_request(req);
        sent++;
        @(posedge clk);
        if (allow_gaps && $urandom_range(0, 9) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    task automatic hold_off(int n);
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending_disp.size() != 0)
            @(posedge clk);
        repeat (50)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [avd_pkg::CfgIdxW-1:0] idx,
                             logic [avd_pkg::RegW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    function automatic logic [avd_pkg::RegW-1:0] rand48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    function automatic logic [15:0] near_one_coef();
        return 16'(16384 + $urandom_range(0, 2000) - 1000);
    endfunction

    // Writes a whole register set; style picks a corner, a random set or a plausible transform.
    task automatic configure(int style);
        logic [avd_pkg::RegW-1:0] vals [6];
        case (style)
            0:
            begin
                foreach (vals[i])
                    vals[i] = '1;
            end
            1:
            begin
                foreach (vals[i])
                    vals[i] = '0;
            end
            2:
            begin
                foreach (vals[i])
                    vals[i] = rand48();
            end
            default:
            begin
                vals[avd_pkg::RegRowX] = {16'($urandom_range(0, 600) - 300),
                                          16'($urandom_range(0, 600) - 300),
                                          near_one_coef()};
                vals[avd_pkg::RegRowY] = {16'($urandom_range(0, 600) - 300), near_one_coef(),
                                          16'($urandom_range(0, 600) - 300)};
                vals[avd_pkg::RegRowZ] = {near_one_coef(), 16'($urandom_range(0, 600) - 300),
                                          16'($urandom_range(0, 600) - 300)};
                vals[avd_pkg::RegTrans] = rand48();
                vals[avd_pkg::RegSpacing] = {16'($urandom_range(1024, 16384)),
                                             16'($urandom_range(1024, 16384)),
                                             16'($urandom_range(1024, 16384))};
                vals[avd_pkg::RegExtent] = {18'($urandom()), 10'($urandom_range(1, 1023)),
                                            10'($urandom_range(1, 1023)),
                                            10'($urandom_range(1, 1023))};
            end
        endcase
        for (int i = 0; i < 6; i++)
            write_reg(avd_pkg::CfgIdxW'(i), vals[i]);
        write_reg(avd_pkg::CfgIdxW'(6), rand48());
        write_reg(avd_pkg::CfgIdxW'(7), rand48());
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_items(int count, bit in_extent);
        avd_pkg::in_t req;
        for (int n = 0; n < count; n++)
        begin
            if (in_extent && $urandom_range(0, 4) != 0)
            begin
                req.col_index = 10'($urandom_range(0, board.regs[avd_pkg::RegExtent][9:0]));
                req.row_index = 10'($urandom_range(0, board.regs[avd_pkg::RegExtent][19:10]));
                req.slice_index = 10'($urandom_range(0, board.regs[avd_pkg::RegExtent][29:20]));
            end
            else
                req = avd_pkg::in_t'(30'($urandom()));
            send_request(req);
        end
    endtask

    initial
    begin
        avd_pkg::in_t req;
        board = new();
        sent = 0;
        allow_gaps = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short directed set: grid corner indices, including all-ones indices.
        for (int pass = 0; pass < 3; pass++)
        begin
            if (pass == 1)
                configure(3);
            if (pass == 2)
                configure(0);
            for (int c = 0; c < 8; c++)
            begin
                req.col_index = c[0] ? 10'd1023 : 10'd0;
                req.row_index = c[1] ? 10'd1023 : 10'd0;
                req.slice_index = c[2] ? 10'd1023 : 10'd0;
                send_request(req);
            end
            drain();
        end

        configure(1);
        random_items(40, 1'b0);
        hold_off(5);
        drain();
        configure(2);
        random_items(60, 1'b0);
        drain();
        for (int ph = 0; ph < 6; ph++)
        begin
            configure(3);
            random_items(70, 1'b1);
            drain();
        end
        configure(0);
        random_items(30, 1'b0);
        drain();
        allow_gaps = 1'b0;
        configure(3);
        random_items(80, 1'b1);
        drain();

        $display("Run covered %0d requests and %0d checked results, %0d of them saturated,",
                 sent, board.checked, board.sat_seen);
        $display("over default, corner, random and near-identity register settings.");
        if (board.errors == 0 && board.pending_disp.size() == 0)
            $display("[affine_voxel_displacement] OK");
        else
            $display("[affine_voxel_displacement] ERROR");
        $finish;
    end

endmodule
